// File: sv/layer_norm_forward_defines.svh
// Assertion macros shared by the layer norm checker.
`ifndef LAYER_NORM_FORWARD_DEFINES_SVH
`define LAYER_NORM_FORWARD_DEFINES_SVH

// Same-cycle implication.
`define LNF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LNF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lnf_pkg.sv
// Shared types and constants of the layer norm block.
`default_nettype none
package lnf_pkg;
  localparam int DEF_MAX_CHANNELS = 64;
  localparam int DATA_W = 16;
  localparam int IDX_W = 6;
  localparam int RSTD_W = 24;
  localparam int SUM_W = 23;
  localparam int CNT_W = 7;
  localparam int VSUM_W = 39;
  localparam int DIVD_W = 55;
  localparam int DIVS_W = 33;
  localparam int WORD_W = 3 * DATA_W;
  localparam logic [15:0] EPS_RESET = 16'd168;
  localparam logic [RSTD_W-1:0] RSTD_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIVD_W-1:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: sv/layer_norm_forward.sv
// Top level of the layer norm block.
// Elements enter one per cycle while busy is low (start high); up to MAX_CHANNELS per row
// are stored and summed. The element marked row_end closes the row and busy rises until
// the row's outputs are out. Per row the back end makes three passes of the shared
// bit-serial divider (mean, variance, 2^54/(var+eps)), 28 root steps, and two passes over
// the element RAM; the last divide and root are skipped if var+eps is zero. Outputs leave
// one word a cycle on result_strobe and cannot be held off; row_last marks the final one.
`default_nettype none
module layer_norm_forward #(
  parameter int MAX_CHANNELS = lnf_pkg::DEF_MAX_CHANNELS,
  localparam int AW = $clog2(MAX_CHANNELS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] element_value,
  input  logic signed [15:0] scale_value,
  input  logic signed [15:0] shift_value,
  input  logic               row_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output logic               result_strobe,
  output logic signed [15:0] normalized_value,
  output logic [5:0]         element_index,
  output logic signed [15:0] row_mean,
  output logic [23:0]        row_rstd,
  output logic               row_last
);
  logic [15:0]                 epsilon_q24;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [lnf_pkg::WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [lnf_pkg::WORD_W-1:0]  ram_rdata;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_empty;
  lnf_pkg::job_t               push_job;
  lnf_pkg::job_t               head_job;
  lnf_pkg::div_req_t           div_req;
  lnf_pkg::div_rsp_t           div_rsp;
  logic                        back_active;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon_q24 <= lnf_pkg::EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      epsilon_q24 <= cfg_data;
    end
  end

  lnf_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .element_value(element_value), .scale_value(scale_value),
    .shift_value(shift_value), .row_end(row_end),
    .q_empty(q_empty), .back_active(back_active),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
    .q_push(q_push), .q_job(push_job)
  );

  lnf_ram #(.WIDTH(lnf_pkg::WORD_W), .DEPTH(MAX_CHANNELS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  lnf_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_job(push_job),
    .pop(q_pop), .empty(q_empty), .head(head_job)
  );

  lnf_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

  lnf_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_job(head_job), .q_pop(q_pop),
    .epsilon_q24(epsilon_q24), .rd_addr(ram_raddr), .rd_data(ram_rdata),
    .div_req(div_req), .div_rsp(div_rsp), .active(back_active),
    .result_strobe(result_strobe), .normalized_value(normalized_value),
    .element_index(element_index), .row_mean(row_mean), .row_rstd(row_rstd),
    .row_last(row_last)
  );
endmodule
`default_nettype wire

// File: sv/lnf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/lnf_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lnf_div (
  input  logic              clk,
  input  logic              rst,
  input  lnf_pkg::div_req_t req,
  output lnf_pkg::div_rsp_t rsp
);
  logic                        running;
  logic                        done;
  logic [5:0]                  cnt;
  logic [lnf_pkg::DIVD_W-1:0]  dvd;
  logic [lnf_pkg::DIVS_W-1:0]  dsr;
  logic [lnf_pkg::DIVS_W-1:0]  rem;
  logic [lnf_pkg::DIVS_W:0]    trial;
  logic                        qbit;

  assign trial = {rem, dvd[lnf_pkg::DIVD_W-1]};
  assign qbit  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= 6'(lnf_pkg::DIVD_W - 1);
        dvd     <= req.dividend;
        dsr     <= req.divisor;
        rem     <= '0;
      end else if (running) begin
        rem <= qbit ? lnf_pkg::DIVS_W'(trial - {1'b0, dsr})
                    : trial[lnf_pkg::DIVS_W-1:0];
        dvd <= {dvd[lnf_pkg::DIVD_W-2:0], qbit};
        if (cnt == 6'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
endmodule
`default_nettype wire

// File: sv/lnf_queue.sv
// Two-entry queue of finished rows between front and back.
`default_nettype none
module lnf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lnf_pkg::job_t push_job,
  input  logic          pop,
  output logic          empty,
  output lnf_pkg::job_t head
);
  lnf_pkg::job_t slots [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    cnt;

  assign empty = (cnt == 2'd0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        slots[wptr] <= push_job;
        wptr        <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// File: sv/lnf_front.sv
// Front end: takes elements, stores the word, keeps the running row sum.
`default_nettype none
module lnf_front #(
  parameter int MAX_CHANNELS = lnf_pkg::DEF_MAX_CHANNELS,
  localparam int AW = $clog2(MAX_CHANNELS),
  localparam int CW = $clog2(MAX_CHANNELS + 1),
  localparam int SW = lnf_pkg::DATA_W + AW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          element_value,
  input  logic signed [15:0]          scale_value,
  input  logic signed [15:0]          shift_value,
  input  logic                        row_end,
  input  logic                        q_empty,
  input  logic                        back_active,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [lnf_pkg::WORD_W-1:0]  ram_wdata,
  output logic                        q_push,
  output lnf_pkg::job_t               q_job
);
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_next;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 accept;
  logic                 take;

  assign busy   = !q_empty || back_active;
  assign accept = start && !busy;
  // elements past the channel limit are dropped
  assign take   = accept && (count < CW'(MAX_CHANNELS));

  assign sum_next   = take ? sum + SW'(element_value) : sum;
  assign count_next = take ? count + CW'(1) : count;

  assign ram_we    = take;
  assign ram_waddr = count[AW-1:0];
  assign ram_wdata = {shift_value, scale_value, element_value};

  assign q_push      = accept && row_end;
  assign q_job.sum   = lnf_pkg::SUM_W'(sum_next);
  assign q_job.count = lnf_pkg::CNT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept) begin
      if (row_end) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/lnf_back.sv
// Back end: mean, variance pass, reciprocal root, output pass over one row.
`default_nettype none
module lnf_back #(
  parameter int MAX_CHANNELS = lnf_pkg::DEF_MAX_CHANNELS,
  localparam int AW = $clog2(MAX_CHANNELS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  lnf_pkg::job_t               q_job,
  output logic                        q_pop,
  input  logic [15:0]                 epsilon_q24,
  output logic [AW-1:0]               rd_addr,
  input  logic [lnf_pkg::WORD_W-1:0]  rd_data,
  output lnf_pkg::div_req_t           div_req,
  input  lnf_pkg::div_rsp_t           div_rsp,
  output logic                        active,
  output logic                        result_strobe,
  output logic signed [15:0]          normalized_value,
  output logic [5:0]                  element_index,
  output logic signed [15:0]          row_mean,
  output logic [23:0]                 row_rstd,
  output logic                        row_last
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MEAN = 7'b0000010,
    S_VAR  = 7'b0000100,
    S_VDIV = 7'b0001000,
    S_RDIV = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                       state;
  logic [6:0]                   n;
  logic                         neg;
  logic signed [15:0]           mean;
  logic [lnf_pkg::VSUM_W-1:0]   vsum;
  logic [23:0]                  rstd;
  logic [6:0]                   idx;
  logic [54:0]                  root_t;
  logic [55:0]                  root_res;
  logic [4:0]                   root_k;

  logic                         rd_v;
  logic [6:0]                   rd_idx;
  logic                         rd_last;
  logic                         sq_v;
  logic [32:0]                  sq;
  logic                         o2_v;
  logic signed [41:0]           o2_p1;
  logic signed [15:0]           o2_scale;
  logic signed [15:0]           o2_shift;
  logic [6:0]                   o2_idx;
  logic                         o2_last;
  logic                         o3_v;
  logic signed [57:0]           o3_p2;
  logic signed [15:0]           o3_shift;
  logic [6:0]                   o3_idx;
  logic                         o3_last;

  logic                         issuing;
  logic                         var_drain;
  logic                         out_drain;
  logic [22:0]                  sum_mag;
  logic [32:0]                  d_sum;
  logic signed [16:0]           df_v;
  logic signed [33:0]           sq_full;
  logic [54:0]                  bitv;
  logic [55:0]                  trial;
  logic                         take_bit;
  logic [55:0]                  res_upd;
  logic [54:0]                  t_upd;
  logic [55:0]                  q_round;
  logic [23:0]                  rstd_sat;
  logic signed [57:0]           v_sum;
  logic signed [57:0]           v_rnd;
  logic signed [57:0]           r_val;
  logic signed [15:0]           r_sat;

  assign active    = (state != S_IDLE);
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign issuing   = ((state == S_VAR) || (state == S_OUT)) && (idx < n);
  assign rd_addr   = idx[AW-1:0];
  assign var_drain = (state == S_VAR) && (idx == n) && !rd_v && !sq_v;
  assign out_drain = (state == S_OUT) && (idx == n) && !rd_v && !o2_v && !o3_v;

  assign sum_mag = q_job.sum[lnf_pkg::SUM_W-1] ? 23'(-q_job.sum) : 23'(q_job.sum);
  assign d_sum   = div_rsp.quot[32:0] + 33'(epsilon_q24);

  // root argument sits in Q.54 below, one result bit per step
  assign bitv     = 55'(1) << {root_k, 1'b0};
  assign trial    = root_res + 56'(bitv);
  assign take_bit = {1'b0, root_t} >= trial;
  assign res_upd  = take_bit ? (root_res >> 1) + 56'(bitv) : (root_res >> 1);
  assign t_upd    = take_bit ? root_t - trial[54:0] : root_t;
  assign q_round  = (res_upd + 56'd1) >> 1;
  assign rstd_sat = (q_round > 56'(lnf_pkg::RSTD_MAX)) ? lnf_pkg::RSTD_MAX : q_round[23:0];

  assign df_v    = $signed({rd_data[15], rd_data[15:0]}) - $signed({mean[15], mean});
  assign sq_full = df_v * df_v;

  // ties away from zero at the 2^26 boundary
  assign v_sum = o3_p2 + (58'(o3_shift) <<< 26);
  assign v_rnd = v_sum + (v_sum[57] ? 58'sh1FFFFFF : 58'sh2000000);
  assign r_val = v_rnd >>> 26;
  assign r_sat = (r_val > 58'sd32767) ? 16'sh7FFF :
                 (r_val < -58'sd32768) ? 16'sh8000 : r_val[15:0];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = 55'(sum_mag) + 55'(q_job.count >> 1);
    div_req.divisor  = 33'(q_job.count);
    case (state)
      S_IDLE: begin
        div_req.start = !q_empty;
      end
      S_VAR: begin
        div_req.start    = var_drain;
        div_req.dividend = 55'(vsum) + 55'(n >> 1);
        div_req.divisor  = 33'(n);
      end
      S_VDIV: begin
        div_req.start    = div_rsp.done && (d_sum != 33'd0);
        div_req.dividend = {1'b1, 54'd0};
        div_req.divisor  = d_sum;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_v          <= 1'b0;
      sq_v          <= 1'b0;
      o2_v          <= 1'b0;
      o3_v          <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      rd_v          <= issuing;
      sq_v          <= rd_v && (state == S_VAR);
      o2_v          <= rd_v && (state == S_OUT);
      o3_v          <= o2_v;
      result_strobe <= o3_v;
      if (issuing) begin
        idx <= idx + 7'd1;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            n     <= q_job.count;
            neg   <= q_job.sum[lnf_pkg::SUM_W-1];
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            mean  <= neg ? -$signed(div_rsp.quot[15:0]) : $signed(div_rsp.quot[15:0]);
            idx   <= 7'd0;
            vsum  <= '0;
            state <= S_VAR;
          end
        end
        S_VAR: begin
          if (sq_v) begin
            vsum <= vsum + lnf_pkg::VSUM_W'(sq);
          end
          if (var_drain) begin
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (div_rsp.done) begin
            if (d_sum == 33'd0) begin
              rstd  <= lnf_pkg::RSTD_MAX;
              idx   <= 7'd0;
              state <= S_OUT;
            end else begin
              state <= S_RDIV;
            end
          end
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            root_t   <= div_rsp.quot;
            root_res <= '0;
            root_k   <= 5'd27;
            state    <= S_ROOT;
          end
        end
        S_ROOT: begin
          root_t   <= t_upd;
          root_res <= res_upd;
          root_k   <= root_k - 5'd1;
          if (root_k == 5'd0) begin
            rstd  <= rstd_sat;
            idx   <= 7'd0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_drain) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= idx;
    rd_last <= (idx == n - 7'd1);
    sq      <= sq_full[32:0];

    o2_p1    <= $signed({1'b0, rstd}) * df_v;
    o2_scale <= rd_data[31:16];
    o2_shift <= rd_data[47:32];
    o2_idx   <= rd_idx;
    o2_last  <= rd_last;

    o3_p2    <= o2_p1 * o2_scale;
    o3_shift <= o2_shift;
    o3_idx   <= o2_idx;
    o3_last  <= o2_last;

    normalized_value <= r_sat;
    element_index    <= 6'(o3_idx);
    row_mean         <= mean;
    row_rstd         <= rstd;
    row_last         <= o3_last;
  end
endmodule
`default_nettype wire

// File: sv/lnf_checker.sv
// Port-level checks of the layer norm block, bound to the top level.
`default_nettype none
`include "layer_norm_forward_defines.svh"
module lnf_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       row_end,
  input logic       result_strobe,
  input logic [5:0] element_index,
  input logic       row_last
);
  `LNF_ASSERT_NEXT(a_row_end_busy, clk, rst, start && !busy && row_end, busy, "row end did not raise busy")
  `LNF_ASSERT_NOW(a_out_while_busy, clk, rst, result_strobe, busy, "result word while idle")
  `LNF_ASSERT_NEXT(a_out_burst, clk, rst, result_strobe && !row_last, result_strobe && (element_index == $past(element_index) + 6'd1), "gap or index skip in row output")
  `LNF_ASSERT_NEXT(a_last_ends, clk, rst, result_strobe && row_last, !result_strobe, "word after last of row")
endmodule

bind layer_norm_forward lnf_checker u_lnf_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .row_end(row_end),
  .result_strobe(result_strobe), .element_index(element_index), .row_last(row_last)
);
`default_nettype wire

// File: tb/sv/tb_layer_norm_forward.sv
// Self-checking testbench for the layer norm block: row traffic, epsilon settings, checks.
`default_nettype none
module tb_layer_norm_forward;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_MAX = lnf_pkg::DEF_MAX_CHANNELS;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 2 * ROW_MAX + 220;

  typedef struct {
    logic signed [15:0] value;
    logic [5:0]         index;
    logic signed [15:0] mean;
    logic [23:0]        rstd;
    logic               last;
  } norm_out_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] element_value, scale_value, shift_value;
  logic row_end;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;
  logic result_strobe;
  logic signed [15:0] normalized_value;
  logic [5:0] element_index;
  logic signed [15:0] row_mean;
  logic [23:0] row_rstd;
  logic row_last;

  // mirror of the block's row state
  logic signed [15:0] row_elem [ROW_MAX];
  logic signed [15:0] row_scale [ROW_MAX];
  logic signed [15:0] row_shift [ROW_MAX];
  longint row_sum;
  int row_count;
  logic [15:0] eps_q24;

  norm_out_t pending_outputs [$];
  int error_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit item_taken;

  layer_norm_forward i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .element_value(element_value), .scale_value(scale_value),
    .shift_value(shift_value), .row_end(row_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .normalized_value(normalized_value),
    .element_index(element_index), .row_mean(row_mean), .row_rstd(row_rstd),
    .row_last(row_last)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned t);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > t) b = b >> 2;
    while (b != 0) begin
      if (t >= res + b) begin
        t = t - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint round_q26(longint v);
    longint half;
    half = 64'sd1 <<< 25;
    if (v >= 0) return (v + half) >>> 26;
    return -((-v + half) >>> 26);
  endfunction

  // closes the row: mean, variance, rstd, then one output per element
  task automatic predict_row();
    longint mag, mean, df, vsum, variance, r;
    longint unsigned d, q;
    logic [23:0] rstd;
    norm_out_t o;
    mag = row_sum < 0 ? -row_sum : row_sum;
    mag = (mag + row_count / 2) / row_count;
    mean = row_sum < 0 ? -mag : mag;
    vsum = 0;
    for (int i = 0; i < row_count; i++) begin
      df = longint'(row_elem[i]) - mean;
      vsum += df * df;
    end
    variance = (vsum + row_count / 2) / row_count;
    d = variance + eps_q24;
    if (d == 0) begin
      rstd = lnf_pkg::RSTD_MAX;
    end else begin
      q = (int_sqrt((64'd1 << 54) / d) + 1) / 2;
      rstd = q > lnf_pkg::RSTD_MAX ? lnf_pkg::RSTD_MAX : q[23:0];
    end
    for (int i = 0; i < row_count; i++) begin
      df = longint'(row_elem[i]) - mean;
      r = round_q26(longint'(rstd) * df * longint'(row_scale[i])
                    + (longint'(row_shift[i]) <<< 26));
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      o.value = r[15:0];
      o.index = i[5:0];
      o.mean = mean[15:0];
      o.rstd = rstd;
      o.last = (i + 1 == row_count);
      pending_outputs.push_back(o);
    end
    row_sum = 0;
    row_count = 0;
  endtask

  task automatic send_element(logic signed [15:0] e, logic signed [15:0] s,
                              logic signed [15:0] h, logic last);
    start <= 1'b1;
    element_value <= e;
    scale_value <= s;
    shift_value <= h;
    row_end <= last;
    do @(posedge clk); while (busy);
    items_sent++;
    if (row_count < ROW_MAX) begin
      row_elem[row_count] = e;
      row_scale[row_count] = s;
      row_shift[row_count] = h;
      row_sum += e;
      row_count++;
    end
    if (last) predict_row();
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return;
    else if (pick < 95) idle_gap($urandom_range(1, 3));
    else idle_gap($urandom_range(10, 60));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [15:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eps_q24 = v;
  endtask

  function automatic logic signed [15:0] rand_word();
    return 16'($urandom_range(0, 65535));
  endfunction

  // element near a row center, so outputs do not all saturate
  function automatic logic signed [15:0] near(int center, int spread);
    int v;
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic test_directed();
    // single element row: zero variance, rstd set by epsilon alone
    send_element(16'sd4096, 16'sd4096, 16'sd0, 1'b1);
    send_element(-16'sd32768, 16'sd32767, -16'sd32768, 1'b1);
    // extremes of every field
    send_element(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_element(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_element(16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
    send_element(-16'sd32768, 16'sd32767, -16'sd1, 1'b1);
    // gentle row, unit gain
    send_element(16'sd4096, 16'sd4096, 16'sd0, 1'b0);
    send_element(-16'sd4096, 16'sd4096, 16'sd0, 1'b0);
    send_element(16'sd2048, 16'sd4096, 16'sd100, 1'b0);
    send_element(16'sd0, 16'sd4096, -16'sd100, 1'b1);
    // tiny spread: zero variance, large rstd
    send_element(16'sd1, 16'sd32767, 16'sd0, 1'b0);
    send_element(16'sd0, -16'sd32768, 16'sd0, 1'b0);
    send_element(16'sd1, 16'sd1, 16'sd5, 1'b1);
    // equal elements, sum negative
    send_element(-16'sd7, 16'sd4096, 16'sd3, 1'b0);
    send_element(-16'sd7, 16'sd4096, 16'sd3, 1'b1);
  endtask

  task automatic test_zero_epsilon();
    write_epsilon(16'd0);
    // variance plus epsilon is zero or one: rstd saturates
    send_element(16'sd1234, 16'sd4096, 16'sd0, 1'b1);
    send_element(16'sd5, 16'sd4096, 16'sd0, 1'b0);
    send_element(16'sd5, 16'sd4096, 16'sd0, 1'b1);
    send_element(16'sd0, 16'sd100, 16'sd0, 1'b0);
    send_element(16'sd1, 16'sd100, 16'sd0, 1'b1);
    wait_drained();
  endtask

  task automatic test_max_epsilon();
    write_epsilon(16'hFFFF);
    send_element(16'sd0, 16'sd4096, 16'sd0, 1'b0);
    send_element(16'sd1, 16'sd4096, 16'sd0, 1'b1);
    send_element(16'sd32767, 16'sd4096, 16'sd0, 1'b0);
    send_element(-16'sd32768, 16'sd4096, 16'sd0, 1'b1);
  endtask

  // full row, then a row that runs past capacity and ends on a dropped word
  task automatic test_long_rows();
    for (int i = 0; i < ROW_MAX; i++)
      send_element(rand_word(), rand_word(), rand_word(), i == ROW_MAX - 1);
    for (int i = 0; i < ROW_MAX + 3; i++) begin
      send_element(near(0, 3000), near(4096, 2000), rand_word(), i == ROW_MAX + 2);
      random_gap();
    end
  endtask

  task automatic test_random_rows(int target);
    int len, center, spread, kind;
    while (items_sent < target) begin
      kind = $urandom_range(0, 9);
      len = kind == 0 ? $urandom_range(50, 70) : $urandom_range(1, 16);
      center = $signed(rand_word()) / 2;
      spread = 1 << $urandom_range(0, 14);
      for (int i = 0; i < len; i++) begin
        if (kind == 1)
          send_element(rand_word(), rand_word(), rand_word(), i == len - 1);
        else
          send_element(near(center, spread), near(0, 8192), near(0, 16384), i == len - 1);
        random_gap();
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  // results cannot be held off: compare each one as it leaves
  always @(posedge clk) begin
    norm_out_t exp_out;
    if (!rst && result_strobe) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("output word with nothing expected");
      end else begin
        exp_out = pending_outputs.pop_front();
        if (normalized_value !== exp_out.value)
          report_mismatch($sformatf("normalized_value %0d, expected %0d",
                                    normalized_value, exp_out.value));
        if (element_index !== exp_out.index)
          report_mismatch($sformatf("element_index %0d, expected %0d",
                                    element_index, exp_out.index));
        if (row_mean !== exp_out.mean)
          report_mismatch($sformatf("row_mean %0d, expected %0d", row_mean, exp_out.mean));
        if (row_rstd !== exp_out.rstd)
          report_mismatch($sformatf("row_rstd %0d, expected %0d", row_rstd, exp_out.rstd));
        if (row_last !== exp_out.last)
          report_mismatch($sformatf("row_last %0b, expected %0b", row_last, exp_out.last));
      end
    end
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    item_taken = (start && !busy) || result_strobe || (cfg_valid && cfg_ready);
    if (rst || item_taken) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no activity for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    element_value <= '0;
    scale_value <= '0;
    shift_value <= '0;
    row_end <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    row_sum = 0;
    row_count = 0;
    eps_q24 = lnf_pkg::EPS_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_zero_epsilon();
    test_max_epsilon();
    test_long_rows();
    write_epsilon(lnf_pkg::EPS_RESET);
    test_random_rows(260);
    write_epsilon(rand_word());
    test_random_rows(360);
    write_epsilon(16'd1);
    test_random_rows(430);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_outputs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
